// ===== hdl/mat4_pkg.sv =====
`timescale 1ns / 1ps

package mat4_pkg;

   // default element format: signed q16.16
   localparam int ELEM_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int POS_BITS  = 4;   // row-major position in a 4x4 matrix
   localparam int TERM_BITS = 2;   // term of one dot product
   localparam int ISSUE_BITS = POS_BITS + TERM_BITS;

   localparam logic [POS_BITS-1:0]  LAST_POS  = 4'd15;
   localparam logic [TERM_BITS-1:0] FIRST_TERM = 2'd0;
   localparam logic [TERM_BITS-1:0] LAST_TERM  = 2'd3;

   // tag that travels beside each multiply-accumulate step
   typedef struct packed {
      logic                valid;
      logic                first;   // first term of a dot product
      logic                last;    // last term of a dot product
      logic [POS_BITS-1:0] pos;     // product element position
   } tag_type;

endpackage

// ===== hdl/mat4_store.sv =====
`timescale 1ns / 1ps

module mat4_store #(
   parameter int ELEM_BITS = mat4_pkg::ELEM_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [mat4_pkg::POS_BITS-1:0]     wr_addr,
   input  logic signed [ELEM_BITS-1:0]       wr_row,
   input  logic signed [ELEM_BITS-1:0]       wr_col,
   input  logic                              rd_en,
   input  logic [mat4_pkg::POS_BITS-1:0]     rd_row_addr,
   input  logic [mat4_pkg::POS_BITS-1:0]     rd_col_addr,
   output logic signed [ELEM_BITS-1:0]       rd_row,
   output logic signed [ELEM_BITS-1:0]       rd_col
);

   localparam int DEPTH = 1 << mat4_pkg::POS_BITS;

   logic signed [ELEM_BITS-1:0] row_mem_ff [DEPTH];
   logic signed [ELEM_BITS-1:0] col_mem_ff [DEPTH];
   logic signed [ELEM_BITS-1:0] rd_row_ff;
   logic signed [ELEM_BITS-1:0] rd_col_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_row;
         col_mem_ff[wr_addr] <= wr_col;
      end
   end

   // registered read, held while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= row_mem_ff[rd_row_addr];
         rd_col_ff <= col_mem_ff[rd_col_addr];
      end
   end

   assign rd_row = rd_row_ff;
   assign rd_col = rd_col_ff;

endmodule

// ===== hdl/mat4_mac.sv =====
`timescale 1ns / 1ps

module mat4_mac #(
   parameter int ELEM_BITS = mat4_pkg::ELEM_BITS_DEF,
   parameter int FRAC_BITS = mat4_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  mat4_pkg::tag_type                 in_tag,
   input  logic signed [ELEM_BITS-1:0]       row_elem,
   input  logic signed [ELEM_BITS-1:0]       col_elem,
   output mat4_pkg::tag_type                 fin_tag,
   output logic signed [ELEM_BITS-1:0]       fin_elem,
   output logic                              fin_sat
);

   localparam int LO_W = (ELEM_BITS + 1) / 2;       // unsigned low half of row element
   localparam int HI_W = ELEM_BITS - LO_W;          // signed high half
   localparam int PW   = 2 * ELEM_BITS;             // exact product
   localparam int AW   = PW + 2;                    // exact sum of four products
   localparam int TW   = AW - ELEM_BITS + 1;        // bits that must agree to fit

   logic signed [LO_W+ELEM_BITS:0]   plo_in;
   logic signed [LO_W+ELEM_BITS:0]   plo_ff;
   logic signed [HI_W+ELEM_BITS-1:0] phi_in;
   logic signed [HI_W+ELEM_BITS-1:0] phi_ff;
   logic signed [PW-1:0]             sum_in;
   logic signed [PW-1:0]             sum_ff;
   logic signed [AW-1:0]             acc_in;
   logic signed [AW-1:0]             acc_ff;
   logic signed [AW-1:0]             shifted;
   logic [TW-1:0]                    top_bits;
   logic                             fits;
   mat4_pkg::tag_type                t2_ff;
   mat4_pkg::tag_type                t3_ff;
   mat4_pkg::tag_type                fin_in;
   mat4_pkg::tag_type                fin_ff;

   // two half-width partial products
   always_comb begin
      plo_in = $signed({1'b0, row_elem[LO_W-1:0]}) * col_elem;
      phi_in = $signed(row_elem[ELEM_BITS-1:LO_W]) * col_elem;
   end

   assign sum_in = PW'(plo_ff) + (PW'(phi_ff) <<< LO_W);

   assign acc_in = t3_ff.first ? AW'(sum_ff) : acc_ff + AW'(sum_ff);

   always_comb begin
      fin_in       = t3_ff;
      fin_in.valid = t3_ff.valid && t3_ff.last;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         sum_ff <= sum_in;
         if (t3_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_ff  <= '0;
         t3_ff  <= '0;
         fin_ff <= '0;
      end else if (advance) begin
         t2_ff  <= in_tag;
         t3_ff  <= t2_ff;
         fin_ff <= fin_in;
      end
   end

   // truncate toward minus infinity, then saturate
   assign shifted  = acc_ff >>> FRAC_BITS;
   assign top_bits = shifted[AW-1:ELEM_BITS-1];
   assign fits     = (&top_bits) || !(|top_bits);

   always_comb begin
      if (fits) begin
         fin_elem = shifted[ELEM_BITS-1:0];
      end else if (shifted[AW-1]) begin
         fin_elem = {1'b1, {(ELEM_BITS-1){1'b0}}};
      end else begin
         fin_elem = {1'b0, {(ELEM_BITS-1){1'b1}}};
      end
   end

   assign fin_sat = !fits;
   assign fin_tag = fin_ff;

endmodule

// ===== hdl/matrix4x4_product.sv =====
`timescale 1ns / 1ps
// after the sixteenth load transaction the read sweep starts; terms pass read, product, sum and accumulator registers
// loads: one transaction per cycle in the load state; each product element takes four multiply-accumulate terms
// a full frame of 16 loads and 16 results is computed by the single shared mac
// loads are refused while the mac reads the two memories; back-pressure stalls and extends that sweep
// reset (synchronous, active high) clears the load and issue counts, fsm, pipeline tags and output valid only

module matrix4x4_product #(
   parameter int ELEM_BITS = mat4_pkg::ELEM_BITS_DEF,
   parameter int FRAC_BITS = mat4_pkg::FRAC_BITS_DEF,
   localparam int IN_W  = ((2 * ELEM_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((ELEM_BITS + mat4_pkg::POS_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // load channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,    // row_factor_element, column_factor_element, zero pad
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata,    // product_element, product_index, zero pad
   output logic             rsp_tuser,    // saturated_flag
   output logic             rsp_tlast     // last_flag
);

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   state_type                              state_ff;
   state_type                              state_in;
   logic [mat4_pkg::POS_BITS-1:0]          load_cnt_ff;
   logic [mat4_pkg::POS_BITS-1:0]          load_cnt_in;
   logic [mat4_pkg::ISSUE_BITS-1:0]        issue_cnt_ff;
   logic [mat4_pkg::ISSUE_BITS-1:0]        issue_cnt_in;
   mat4_pkg::tag_type                      tag1_ff;
   mat4_pkg::tag_type                      tag1_in;

   logic                                   load_xact;
   logic                                   advance;
   logic                                   issue;
   logic [mat4_pkg::POS_BITS-1:0]          issue_pos;
   logic [mat4_pkg::TERM_BITS-1:0]         issue_term;
   logic [mat4_pkg::POS_BITS-1:0]          rd_row_addr;
   logic [mat4_pkg::POS_BITS-1:0]          rd_col_addr;
   logic signed [ELEM_BITS-1:0]            rd_row;
   logic signed [ELEM_BITS-1:0]            rd_col;

   mat4_pkg::tag_type                      fin_tag;
   logic signed [ELEM_BITS-1:0]            fin_elem;
   logic                                   fin_sat;

   logic                                   rsp_valid_ff;
   logic signed [ELEM_BITS-1:0]            rsp_elem_ff;
   logic [mat4_pkg::POS_BITS-1:0]          rsp_pos_ff;
   logic                                   rsp_sat_ff;
   logic                                   rsp_last_ff;

   // loads are taken only outside the read sweep, so a write never meets a read
   // of the same entry and the memories need no forwarding
   assign req_tready = (state_ff == ST_LOAD);
   assign load_xact  = req_tvalid && req_tready;

   // the whole mac pipeline moves only when the output register can take a result
   assign advance = !rsp_valid_ff || rsp_tready;
   assign issue   = (state_ff == ST_CALC) && advance;

   // issue counter: product position in the upper bits, term in the lower bits
   assign issue_pos   = issue_cnt_ff[mat4_pkg::ISSUE_BITS-1:mat4_pkg::TERM_BITS];
   assign issue_term  = issue_cnt_ff[mat4_pkg::TERM_BITS-1:0];
   // row factor (i,k) and column factor (k,j)
   assign rd_row_addr = {issue_pos[mat4_pkg::POS_BITS-1:mat4_pkg::TERM_BITS], issue_term};
   assign rd_col_addr = {issue_term, issue_pos[mat4_pkg::TERM_BITS-1:0]};

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      issue_cnt_in = issue_cnt_ff;
      case (state_ff)
         ST_LOAD: begin
            if (load_xact) begin
               load_cnt_in = load_cnt_ff + 1'b1;
               if (load_cnt_ff == mat4_pkg::LAST_POS) begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (issue) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
               // after the final read the memories are free for the next frame
               if (issue_cnt_ff == '1) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      tag1_in       = tag1_ff;
      if (advance) begin
         tag1_in.valid = issue;
         tag1_in.first = (issue_term == mat4_pkg::FIRST_TERM);
         tag1_in.last  = (issue_term == mat4_pkg::LAST_TERM);
         tag1_in.pos   = issue_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         load_cnt_ff  <= '0;
         issue_cnt_ff <= '0;
         tag1_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         issue_cnt_ff <= issue_cnt_in;
         tag1_ff      <= tag1_in;
      end
   end

   mat4_store #(
      .ELEM_BITS (ELEM_BITS)
   ) u_store (
      .clock       (clock),
      .wr_en       (load_xact),
      .wr_addr     (load_cnt_ff),
      .wr_row      (req_tdata[ELEM_BITS-1:0]),
      .wr_col      (req_tdata[2*ELEM_BITS-1:ELEM_BITS]),
      .rd_en       (issue),
      .rd_row_addr (rd_row_addr),
      .rd_col_addr (rd_col_addr),
      .rd_row      (rd_row),
      .rd_col      (rd_col)
   );

   mat4_mac #(
      .ELEM_BITS (ELEM_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_tag   (tag1_ff),
      .row_elem (rd_row),
      .col_elem (rd_col),
      .fin_tag  (fin_tag),
      .fin_elem (fin_elem),
      .fin_sat  (fin_sat)
   );

   // output register: holds a result until its transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fin_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_elem_ff <= fin_elem;
         rsp_pos_ff  <= fin_tag.pos;
         rsp_sat_ff  <= fin_sat;
         rsp_last_ff <= (fin_tag.pos == mat4_pkg::LAST_POS);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_pos_ff, rsp_elem_ff});
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a stalled pipeline must not lose or skip a read
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(issue_cnt_ff))
      else $error("issue counter moved during a stall");

   // the read sweep starts only after the sixteenth load
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) && (state_in == ST_CALC) |-> load_cnt_ff == mat4_pkg::LAST_POS)
      else $error("read sweep started on an incomplete frame");

   // while reading, the load count sits at the frame start
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC) |-> load_cnt_ff == '0)
      else $error("load count not at frame start during read sweep");

   // the final result of a frame carries the final position
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_pos_ff == mat4_pkg::LAST_POS)
      else $error("last flag on a result that is not the final element");
`endif

endmodule
